// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high
`define TME_ASSERT_IMPL(lbl, clk, dis, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("tme assertion failed (same cycle)");

// Next-cycle implication, disabled while dis is high
`define TME_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("tme assertion failed (next cycle)");

`endif

// ----- hdl/tme_pkg.sv -----
// Shared constants and types of the tape engine: defaults, opcodes, move codes.
// Depends on nothing.
package tme_pkg;

   // Default sizes of the machine
   localparam int TAPE_CELLS_DEF     = 8;
   localparam int MACHINE_STATES_DEF = 8;
   localparam int ALPHABET_SIZE_DEF  = 3;

   // Cells shown in the tape image word, two bits each
   localparam int IMAGE_CELLS = 8;

   // Fixed field widths of the words
   localparam int OPCODE_W   = 3;
   localparam int STATE_IN_W = 3;
   localparam int SYM_IN_W   = 2;
   localparam int MOVE_W     = 2;
   localparam int IMAGE_W    = 16;
   localparam int HEAD_OUT_W = 3;
   localparam int STATE_OUT_W = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD_RULE = 3'd0,
      OP_CURSOR_R  = 3'd1,
      OP_CURSOR_L  = 3'd2,
      OP_CYCLE_SYM = 3'd3,
      OP_START     = 3'd4,
      OP_STEP      = 3'd5
   } opcode_type;

   localparam logic [MOVE_W-1:0] MOVE_STAY  = 2'd0;
   localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd1;
   localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd2;

endpackage

// ----- hdl/tme_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on tme_pkg for field widths.
interface tme_req_if;
   logic                                valid;
   logic                                ready;
   logic [tme_pkg::OPCODE_W-1:0]        opcode;
   logic [tme_pkg::STATE_IN_W-1:0]      rule_state;
   logic [tme_pkg::SYM_IN_W-1:0]        rule_symbol;
   logic [tme_pkg::SYM_IN_W-1:0]        rule_new_symbol;
   logic [tme_pkg::MOVE_W-1:0]          rule_move;
   logic [tme_pkg::STATE_IN_W-1:0]      rule_next_state;
   logic                                rule_final;

   modport source (output valid, opcode, rule_state, rule_symbol, rule_new_symbol,
                   rule_move, rule_next_state, rule_final, input ready);
   modport sink   (input valid, opcode, rule_state, rule_symbol, rule_new_symbol,
                   rule_move, rule_next_state, rule_final, output ready);
endinterface

interface tme_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tme_pkg::IMAGE_W-1:0]         tape_image;
   logic [tme_pkg::HEAD_OUT_W-1:0]      head_position;
   logic [tme_pkg::STATE_OUT_W-1:0]     machine_state;
   logic                                running;
   logic                                halted;
   logic                                refused;

   modport source (output valid, tape_image, head_position, machine_state, running,
                   halted, refused, input ready);
   modport sink   (input valid, tape_image, head_position, machine_state, running,
                   halted, refused, output ready);
endinterface

// ----- hdl/tme_rule_ram.sv -----
// Rule table RAM: one write port, one registered read port, per-entry valid bits
// so that never-written entries read as zero after reset. No package needed.
module tme_rule_ram #(
   parameter int AW = 5,
   parameter int DW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   localparam int DEPTH = 2 ** AW;

   logic [DW-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DW-1:0] rd_data_ff;

   // Storage array, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Valid bits: cleared by reset, set on first write
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Registered read; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/turing_machine_tape_engine.sv -----
// Top level of the table-driven Turing machine tape engine.
// Depends on tme_pkg, tme_if (tme_req_if, tme_rsp_if) and tme_rule_ram.
//
// Each request word yields one response word reporting tape, head, state and
// flags. A word is accepted into a single execute stage and its response lands
// in an output register. Load, cursor, cycle and start words are taken one per
// cycle while the response side does not stall. A step word is taken only when
// the execute stage is empty, because its rule lookup is a registered read of
// the rule RAM addressed by the current state and the symbol under the head,
// both of which the previous word may change; so each step waits until the
// previous word has left the execute stage.
// Rule RAM entries come out of reset as zero through per-entry valid bits, so
// there is no clearing pass.
module turing_machine_tape_engine #(
   parameter int TAPE_CELLS     = tme_pkg::TAPE_CELLS_DEF,
   parameter int MACHINE_STATES = tme_pkg::MACHINE_STATES_DEF,
   parameter int ALPHABET_SIZE  = tme_pkg::ALPHABET_SIZE_DEF
) (
   input logic        clock,
   input logic        reset,
   tme_req_if.sink    req_bus,
   tme_rsp_if.source  rsp_bus
);

   localparam int HW     = $clog2(TAPE_CELLS);
   localparam int SW     = $clog2(MACHINE_STATES);
   localparam int YW     = $clog2(ALPHABET_SIZE);
   localparam int RAM_AW = SW + YW;
   localparam int RAM_DW = YW + tme_pkg::MOVE_W + SW;
   localparam int SHOWN  = (TAPE_CELLS < tme_pkg::IMAGE_CELLS) ?
                           TAPE_CELLS : tme_pkg::IMAGE_CELLS;

   // Architectural state
   logic [YW-1:0] tape_ff [TAPE_CELLS];
   logic [YW-1:0] tape_in [TAPE_CELLS];
   logic [HW-1:0] head_ff, head_in;
   logic [SW-1:0] state_ff, state_in;
   logic          run_ff, run_in;
   logic          final_ff [MACHINE_STATES];
   logic          final_in [MACHINE_STATES];
   logic          cur_final_ff, cur_final_in;   // final mark of state_ff

   // Execute stage
   logic                                 s1_valid_ff, s1_valid_in;
   tme_pkg::opcode_type                  s1_op_ff;
   logic [tme_pkg::STATE_IN_W-1:0]       s1_state_ff;
   logic [tme_pkg::SYM_IN_W-1:0]         s1_sym_ff;
   logic [tme_pkg::SYM_IN_W-1:0]         s1_nsym_ff;
   logic [tme_pkg::MOVE_W-1:0]           s1_move_ff;
   logic [tme_pkg::STATE_IN_W-1:0]       s1_next_ff;
   logic                                 s1_fin_ff;

   // Output register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [tme_pkg::IMAGE_W-1:0]          rsp_image_ff, rsp_image_in;
   logic [tme_pkg::HEAD_OUT_W-1:0]       rsp_head_ff;
   logic [tme_pkg::STATE_OUT_W-1:0]      rsp_state_ff;
   logic                                 rsp_run_ff, rsp_halt_ff, rsp_refused_ff;
   logic                                 refused_in;

   // Handshake and RAM signals
   logic              req_fire, req_is_step, s1_fire;
   logic              ram_we;
   logic [RAM_AW-1:0] ram_waddr, ram_raddr;
   logic [RAM_DW-1:0] ram_wdata, ram_rdata;
   logic [YW-1:0]     rd_nsym;
   logic [tme_pkg::MOVE_W-1:0] rd_move;
   logic [SW-1:0]     rd_next;
   logic [YW-1:0]     head_cell;
   logic              load_st_ok, load_rule_ok;
   logic              nz_found;
   logic [HW-1:0]     nz_pos;

   // Handshake: a step waits for an empty execute stage
   assign req_is_step  = (req_bus.opcode == tme_pkg::OP_STEP);
   assign s1_fire      = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || (s1_fire && !req_is_step);
   assign req_fire     = req_bus.valid && req_bus.ready;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);

   // Rule lookup issued at accept time
   assign head_cell = tape_ff[head_ff];
   assign ram_raddr = {state_ff, head_cell};

   tme_rule_ram #(
      .AW (RAM_AW),
      .DW (RAM_DW)
   ) u_rule_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_fire && req_is_step),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign {rd_nsym, rd_move, rd_next} = ram_rdata;

   // Load validity checks
   assign load_st_ok   = int'(s1_state_ff) < MACHINE_STATES;
   assign load_rule_ok = (int'(s1_sym_ff) < ALPHABET_SIZE) &&
                         (int'(s1_nsym_ff) < ALPHABET_SIZE) &&
                         (int'(s1_next_ff) < MACHINE_STATES);
   assign ram_waddr = {SW'(s1_state_ff), YW'(s1_sym_ff)};
   assign ram_wdata = {YW'(s1_nsym_ff), s1_move_ff, SW'(s1_next_ff)};

   // Rightmost non-blank cell for start
   always_comb begin
      nz_found = 1'b0;
      nz_pos   = '0;
      for (int i = 0; i < TAPE_CELLS; i++) begin
         if (tape_ff[i] != '0) begin
            nz_found = 1'b1;
            nz_pos   = HW'(i);
         end
      end
   end

   // Execute: next architectural state
   always_comb begin
      tape_in      = tape_ff;
      head_in      = head_ff;
      state_in     = state_ff;
      run_in       = run_ff;
      final_in     = final_ff;
      cur_final_in = cur_final_ff;
      refused_in   = 1'b0;
      ram_we       = 1'b0;
      if (s1_fire) begin
         unique case (s1_op_ff)
            tme_pkg::OP_LOAD_RULE: begin
               if (load_st_ok) begin
                  final_in[SW'(s1_state_ff)] = s1_fin_ff;
                  if (SW'(s1_state_ff) == state_ff) begin
                     cur_final_in = s1_fin_ff;
                  end
                  ram_we = load_rule_ok;
               end
            end
            tme_pkg::OP_CURSOR_R: begin
               head_in = (head_ff == HW'(TAPE_CELLS - 1)) ? '0 : head_ff + HW'(1);
               run_in  = 1'b0;
            end
            tme_pkg::OP_CURSOR_L: begin
               head_in = (head_ff == '0) ? HW'(TAPE_CELLS - 1) : head_ff - HW'(1);
               run_in  = 1'b0;
            end
            tme_pkg::OP_CYCLE_SYM: begin
               tape_in[head_ff] = (head_cell == YW'(ALPHABET_SIZE - 1)) ?
                                  '0 : head_cell + YW'(1);
               run_in = 1'b0;
            end
            tme_pkg::OP_START: begin
               if (nz_found) begin
                  head_in      = nz_pos;
                  state_in     = '0;
                  run_in       = 1'b1;
                  cur_final_in = final_ff[0];
               end else begin
                  refused_in = 1'b1;
               end
            end
            tme_pkg::OP_STEP: begin
               if (run_ff && !cur_final_ff) begin
                  tape_in[head_ff] = rd_nsym;
                  if (rd_move == tme_pkg::MOVE_LEFT) begin
                     if (head_ff != '0) head_in = head_ff - HW'(1);
                  end else if (rd_move == tme_pkg::MOVE_RIGHT) begin
                     if (head_ff != HW'(TAPE_CELLS - 1)) head_in = head_ff + HW'(1);
                  end
                  state_in     = rd_next;
                  cur_final_in = final_ff[rd_next];
               end
            end
            default: ;
         endcase
      end
   end

   // Response image from the updated tape
   always_comb begin
      rsp_image_in = '0;
      for (int i = 0; i < SHOWN; i++) begin
         rsp_image_in[2*i +: 2] = 2'(tape_in[i]);
      end
   end

   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_bus.ready);

   // Control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         state_ff     <= '0;
         run_ff       <= 1'b0;
         cur_final_ff <= 1'b0;
         for (int i = 0; i < TAPE_CELLS; i++) tape_ff[i] <= '0;
         for (int i = 0; i < MACHINE_STATES; i++) final_ff[i] <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         state_ff     <= state_in;
         run_ff       <= run_in;
         cur_final_ff <= cur_final_in;
         tape_ff      <= tape_in;
         final_ff     <= final_in;
      end
   end

   // Execute stage payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= tme_pkg::opcode_type'(req_bus.opcode);
         s1_state_ff <= req_bus.rule_state;
         s1_sym_ff   <= req_bus.rule_symbol;
         s1_nsym_ff  <= req_bus.rule_new_symbol;
         s1_move_ff  <= req_bus.rule_move;
         s1_next_ff  <= req_bus.rule_next_state;
         s1_fin_ff   <= req_bus.rule_final;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_image_ff   <= rsp_image_in;
         rsp_head_ff    <= tme_pkg::HEAD_OUT_W'(head_in);
         rsp_state_ff   <= tme_pkg::STATE_OUT_W'(state_in);
         rsp_run_ff     <= run_in;
         rsp_halt_ff    <= run_in && cur_final_in;
         rsp_refused_ff <= refused_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.tape_image    = rsp_image_ff;
   assign rsp_bus.head_position = rsp_head_ff;
   assign rsp_bus.machine_state = rsp_state_ff;
   assign rsp_bus.running       = rsp_run_ff;
   assign rsp_bus.halted        = rsp_halt_ff;
   assign rsp_bus.refused       = rsp_refused_ff;

endmodule

// ----- hdl/tme_checker.sv -----
// Port-level checker for the tape engine, bound to the top level.
// Depends on assert_macros.svh and turing_machine_tape_engine.
`include "assert_macros.svh"

module tme_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_tape_image,
   input logic        rsp_running,
   input logic        rsp_halted,
   input logic        rsp_refused
);

   // No response word right after reset
   `TME_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

   // A stalled response word stays offered
   `TME_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Halted only while running
   `TME_ASSERT_IMPL(a_halt_run, clock, reset, rsp_valid && rsp_halted, rsp_running)

   // A refused start means a blank tape
   `TME_ASSERT_IMPL(a_refuse_blank, clock, reset, rsp_valid && rsp_refused,
                    rsp_tape_image == 16'd0)

endmodule

bind turing_machine_tape_engine tme_checker u_tme_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_tape_image (rsp_bus.tape_image),
   .rsp_running    (rsp_bus.running),
   .rsp_halted     (rsp_bus.halted),
   .rsp_refused    (rsp_bus.refused)
);

// ----- bench/tb_turing_machine_tape_engine.sv -----
`timescale 1ns / 1ps
// Testbench for turing_machine_tape_engine: directed edge cases, random rule programs, noise.
// Depends on tme_pkg, tme_if and the engine RTL; checks every response word against a predictor.
module tb_turing_machine_tape_engine;

   localparam int CELLS   = tme_pkg::TAPE_CELLS_DEF;
   localparam int STATES  = tme_pkg::MACHINE_STATES_DEF;
   localparam int SYMBOLS = tme_pkg::ALPHABET_SIZE_DEF;

   // Codes the package has no name for
   localparam logic [tme_pkg::OPCODE_W-1:0] OP_RESERVED_6 = 3'd6;
   localparam logic [tme_pkg::OPCODE_W-1:0] OP_RESERVED_7 = 3'd7;
   localparam logic [tme_pkg::MOVE_W-1:0]   MOVE_UNUSED   = 2'd3;
   localparam logic [tme_pkg::SYM_IN_W-1:0] SYM_INVALID   = 2'd3;

   localparam int TARGET_WORDS = 1250;

   typedef struct packed {
      logic [tme_pkg::OPCODE_W-1:0]   opcode;
      logic [tme_pkg::STATE_IN_W-1:0] rule_state;
      logic [tme_pkg::SYM_IN_W-1:0]   rule_symbol;
      logic [tme_pkg::SYM_IN_W-1:0]   rule_new_symbol;
      logic [tme_pkg::MOVE_W-1:0]     rule_move;
      logic [tme_pkg::STATE_IN_W-1:0] rule_next_state;
      logic                           rule_final;
   } cmd_type;

   typedef struct packed {
      logic [tme_pkg::IMAGE_W-1:0]     tape_image;
      logic [tme_pkg::HEAD_OUT_W-1:0]  head_position;
      logic [tme_pkg::STATE_OUT_W-1:0] machine_state;
      logic                            running;
      logic                            halted;
      logic                            refused;
   } status_type;

   logic clock;
   logic reset;

   tme_req_if req_bus ();
   tme_rsp_if rsp_bus ();

   turing_machine_tape_engine u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predicted machine
   logic [tme_pkg::SYM_IN_W-1:0]   rule_write [STATES][SYMBOLS];
   logic [tme_pkg::MOVE_W-1:0]     rule_shift [STATES][SYMBOLS];
   logic [tme_pkg::STATE_IN_W-1:0] rule_goto  [STATES][SYMBOLS];
   logic                           halt_mark  [STATES];
   logic [1:0]                     tape       [CELLS];
   logic [2:0]                     head_q;
   logic [2:0]                     state_q;
   logic                           run_q;

   status_type expected_status[$];

   int  words_sent;
   int  words_checked;
   int  mismatches;
   int  starts_refused;
   int  halts_seen;
   bit  gaps_on;
   bit  stalls_on;
   int  stall_left;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Applies one request word to the predicted machine and reports its status
   function automatic status_type machine_apply(input cmd_type c);
      logic [2:0]  h;
      logic [1:0]  rd;
      logic [1:0]  mv;
      logic        refused;
      status_type  s;
      refused = 1'b0;
      h = head_q;
      case (c.opcode)
         tme_pkg::OP_LOAD_RULE: begin
            halt_mark[c.rule_state] = c.rule_final;
            if (c.rule_symbol < SYMBOLS && c.rule_new_symbol < SYMBOLS) begin
               rule_write[c.rule_state][c.rule_symbol] = c.rule_new_symbol;
               rule_shift[c.rule_state][c.rule_symbol] = c.rule_move;
               rule_goto[c.rule_state][c.rule_symbol]  = c.rule_next_state;
            end
         end
         tme_pkg::OP_CURSOR_R: begin
            head_q = (h == CELLS - 1) ? 3'd0 : h + 3'd1;
            run_q  = 1'b0;
         end
         tme_pkg::OP_CURSOR_L: begin
            head_q = (h == 0) ? 3'(CELLS - 1) : h - 3'd1;
            run_q  = 1'b0;
         end
         tme_pkg::OP_CYCLE_SYM: begin
            tape[h] = (tape[h] + 1 < SYMBOLS) ? tape[h] + 2'd1 : 2'd0;
            run_q   = 1'b0;
         end
         tme_pkg::OP_START: begin
            refused = 1'b1;
            for (int i = CELLS - 1; i >= 0; i--) begin
               if (refused && tape[i] != 2'd0) begin
                  head_q  = 3'(i);
                  state_q = 3'd0;
                  run_q   = 1'b1;
                  refused = 1'b0;
               end
            end
         end
         tme_pkg::OP_STEP: begin
            if (run_q && !halt_mark[state_q]) begin
               rd = tape[h];
               mv = rule_shift[state_q][rd];
               tape[h] = rule_write[state_q][rd];
               if (mv == tme_pkg::MOVE_LEFT && h > 0)
                  h = h - 3'd1;
               else if (mv == tme_pkg::MOVE_RIGHT && h < CELLS - 1)
                  h = h + 3'd1;
               head_q  = h;
               state_q = rule_goto[state_q][rd];
            end
         end
         default: ;
      endcase
      for (int i = 0; i < CELLS; i++)
         s.tape_image[2*i +: 2] = tape[i];
      s.head_position = head_q;
      s.machine_state = state_q;
      s.running       = run_q;
      s.halted        = run_q && halt_mark[state_q];
      s.refused       = refused;
      return s;
   endfunction

   // Word with the given opcode and random content in every other field
   function automatic cmd_type random_word(input logic [tme_pkg::OPCODE_W-1:0] op);
      cmd_type c;
      c.opcode          = op;
      c.rule_state      = 3'($urandom_range(0, 7));
      c.rule_symbol     = 2'($urandom_range(0, 3));
      c.rule_new_symbol = 2'($urandom_range(0, 3));
      c.rule_move       = 2'($urandom_range(0, 3));
      c.rule_next_state = 3'($urandom_range(0, 7));
      c.rule_final      = 1'($urandom_range(0, 1));
      return c;
   endfunction

   function automatic cmd_type make_rule(input logic [2:0] st, input logic [1:0] sym,
                                         input logic [1:0] nsym, input logic [1:0] mv,
                                         input logic [2:0] nxt, input logic fin);
      cmd_type c;
      c = '{tme_pkg::OP_LOAD_RULE, st, sym, nsym, mv, nxt, fin};
      return c;
   endfunction

   // Drives one word, waits for acceptance and records its predicted status
   task automatic send_word(input cmd_type c);
      status_type s;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_bus.opcode          = c.opcode;
      req_bus.rule_state      = c.rule_state;
      req_bus.rule_symbol     = c.rule_symbol;
      req_bus.rule_new_symbol = c.rule_new_symbol;
      req_bus.rule_move       = c.rule_move;
      req_bus.rule_next_state = c.rule_next_state;
      req_bus.rule_final      = c.rule_final;
      req_bus.valid           = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      s = machine_apply(c);
      expected_status.push_back(s);
      words_sent++;
      if (s.refused) starts_refused++;
      if (s.halted) halts_seen++;
   endtask

   // Response checker: one word per handshake against the oldest prediction
   function automatic void check_field(input string name, input logic [15:0] exp_v,
                                       input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      status_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_status.size() == 0) begin
            $error("response word with no request pending");
            mismatches++;
         end else begin
            e = expected_status.pop_front();
            words_checked++;
            check_field("tape_image", e.tape_image, rsp_bus.tape_image);
            check_field("head_position", 16'(e.head_position), 16'(rsp_bus.head_position));
            check_field("machine_state", 16'(e.machine_state), 16'(rsp_bus.machine_state));
            check_field("running", 16'(e.running), 16'(rsp_bus.running));
            check_field("halted", 16'(e.halted), 16'(rsp_bus.halted));
            check_field("refused", 16'(e.refused), 16'(rsp_bus.refused));
         end
      end
   end

   // Response-side stalls in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
         rsp_bus.ready = 1'b0;
         stall_left = $urandom_range(1, 13) - 1;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // Edge cases: empty tape, wraps, bad loads, clamped move, halting, edits while running
   task automatic test_directed();
      send_word(random_word(tme_pkg::OP_STEP));
      send_word(random_word(OP_RESERVED_6));
      send_word(random_word(OP_RESERVED_7));
      send_word(random_word(tme_pkg::OP_START));
      send_word(random_word(tme_pkg::OP_CURSOR_L));
      send_word(random_word(tme_pkg::OP_CYCLE_SYM));
      send_word(random_word(tme_pkg::OP_CYCLE_SYM));
      send_word(random_word(tme_pkg::OP_CURSOR_R));
      send_word(random_word(tme_pkg::OP_CYCLE_SYM));
      send_word(make_rule(3'd4, SYM_INVALID, 2'd1, tme_pkg::MOVE_RIGHT, 3'd2, 1'b1));
      send_word(make_rule(3'd0, 2'd1, SYM_INVALID, tme_pkg::MOVE_LEFT, 3'd3, 1'b0));
      send_word(make_rule(3'd0, 2'd2, 2'd1, tme_pkg::MOVE_RIGHT, 3'd1, 1'b0));
      send_word(make_rule(3'd1, 2'd1, 2'd0, MOVE_UNUSED, 3'd2, 1'b0));
      send_word(make_rule(3'd2, 2'd0, 2'd2, tme_pkg::MOVE_LEFT, 3'd3, 1'b0));
      send_word(make_rule(3'd3, 2'd0, 2'd0, tme_pkg::MOVE_LEFT, 3'd0, 1'b1));
      send_word(random_word(tme_pkg::OP_START));
      // right edge clamp, move code three, then into the final state
      repeat (4) send_word(random_word(tme_pkg::OP_STEP));
      send_word(random_word(tme_pkg::OP_CURSOR_R));
      send_word(random_word(tme_pkg::OP_STEP));
      send_word(make_rule(3'd3, 2'd0, 2'd0, tme_pkg::MOVE_LEFT, 3'd0, 1'b0));
   endtask

   // Loads some rules, edits the tape, starts and steps, with stray words mixed in
   task automatic run_program(input int n_steps);
      cmd_type c;
      repeat ($urandom_range(4, 24)) begin
         c = make_rule(3'($urandom_range(0, 7)), 2'($urandom_range(0, 2)),
                       2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)),
                       3'($urandom_range(0, 7)), $urandom_range(0, 7) == 0);
         if ($urandom_range(0, 15) == 0)
            c.rule_move = MOVE_UNUSED;
         send_word(c);
      end
      repeat ($urandom_range(2, 12))
         send_word(random_word(3'($urandom_range(tme_pkg::OP_CURSOR_R,
                                                 tme_pkg::OP_CYCLE_SYM))));
      send_word(random_word(tme_pkg::OP_START));
      repeat (n_steps) begin
         if ($urandom_range(0, 24) == 0)
            send_word(random_word(3'($urandom_range(0, 7))));
         else
            send_word(random_word(tme_pkg::OP_STEP));
      end
   endtask

   task automatic test_random_programs(input int stop_at);
      while (words_sent < stop_at)
         run_program($urandom_range(6, 40));
   endtask

   task automatic test_random_noise(input int count);
      repeat (count) send_word(random_word(3'($urandom_range(0, 7))));
   endtask

   task automatic test_back_to_back(input int stop_at);
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      while (words_sent < stop_at)
         run_program($urandom_range(10, 30));
   endtask

   initial begin
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.opcode          = '0;
      req_bus.rule_state      = '0;
      req_bus.rule_symbol     = '0;
      req_bus.rule_new_symbol = '0;
      req_bus.rule_move       = '0;
      req_bus.rule_next_state = '0;
      req_bus.rule_final      = 1'b0;
      rsp_bus.ready           = 1'b0;
      words_sent = 0;
      words_checked = 0;
      mismatches = 0;
      starts_refused = 0;
      halts_seen = 0;
      stall_left = 0;
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      // predictor matches the reset state of the engine
      for (int s = 0; s < STATES; s++) begin
         halt_mark[s] = 1'b0;
         for (int y = 0; y < SYMBOLS; y++) begin
            rule_write[s][y] = '0;
            rule_shift[s][y] = tme_pkg::MOVE_STAY;
            rule_goto[s][y]  = '0;
         end
      end
      for (int i = 0; i < CELLS; i++)
         tape[i] = 2'd0;
      head_q = '0;
      state_q = '0;
      run_q = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_programs(TARGET_WORDS * 3 / 5);
      test_random_noise(250);
      test_random_programs(TARGET_WORDS * 17 / 20);
      test_back_to_back(TARGET_WORDS);

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d request words, %0d response words checked, %0d mismatches",
               words_sent, words_checked, mismatches);
      $display("Refused starts: %0d, words reporting a halted machine: %0d",
               starts_refused, halts_seen);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("Timeout with %0d responses still pending", expected_status.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
